// ----- rtl/core/dtfp_pkg.sv -----
// Shared types and constants of the decimal text to fixed-point parser.
`default_nettype none

package dtfp_pkg;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_PLACES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_VALUE = 1'b1;

    // Limits
    localparam logic [4:0]  MAX_FRAC_PLACES = 5'd18;
    localparam logic [63:0] MAG_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SCALE_LIMIT     = MAG_MAX / 64'd10;
    localparam logic [13:0] EXP_CAP         = 14'd16383;
    localparam logic [15:0] PLACES_FLOOR    = 16'h8000;
    localparam logic [6:0]  UP_STEPS_MAX    = 7'd64;
    localparam logic [6:0]  DIV_STEPS_MAX   = 7'd25;
    localparam logic [3:0]  ROUND_DIGIT     = 4'd5;

    // Largest magnitude that still takes digit d without passing MAG_MAX
    localparam logic [63:0] PUSH_LIMIT [10] = '{
        (MAG_MAX - 64'd0) / 64'd10, (MAG_MAX - 64'd1) / 64'd10,
        (MAG_MAX - 64'd2) / 64'd10, (MAG_MAX - 64'd3) / 64'd10,
        (MAG_MAX - 64'd4) / 64'd10, (MAG_MAX - 64'd5) / 64'd10,
        (MAG_MAX - 64'd6) / 64'd10, (MAG_MAX - 64'd7) / 64'd10,
        (MAG_MAX - 64'd8) / 64'd10, (MAG_MAX - 64'd9) / 64'd10
    };

    // Output beat layout
    localparam int unsigned OUT_TDATA_W = 88;
    localparam int unsigned OUT_TUSER_W = 3;

    // How a finished number is to be scaled
    typedef enum logic [1:0] {
        K_ERR,
        K_INT,
        K_FRAC,
        K_EXP
    } t_kind;

    // Commands from the controller
    typedef struct packed {
        logic take;
        logic setup;
        logic up_step;
        logic div_step;
        logic round_up;
        logic emit;
    } t_cmd;

    // Status of the scaling unit
    typedef struct packed {
        logic setup_up;
        logic iter_zero;
        logic iter_one;
        logic work_zero;
        logic byte_first;
        logic byte_last;
    } t_scale_st;

    // Status seen by the controller
    typedef struct packed {
        logic      fin_req;
        logic      is_err;
        t_scale_st sc;
    } t_status;

    // Parser state handed to the scaling unit and the output stage
    typedef struct packed {
        logic [63:0] accum;
        logic [63:0] rounded;
        logic [15:0] places_left;
        logic [13:0] exp_value;
        logic        exp_neg;
        logic        exp_dig;
        logic        negative;
        logic [15:0] used;
        logic        ovf;
        t_kind       kind;
        logic        on_char;
        logic [7:0]  stop_char;
    } t_parse_st;

endpackage

`default_nettype wire

// ----- rtl/core/dtfp_parse.sv -----
// Character parser: sign, digits, point, exponent and character count.
`default_nettype none

module dtfp_parse
    import dtfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic [7:0] i_ch,
    input  logic      i_last,
    input  logic [4:0] i_frac_places,
    output logic      o_fin_req,
    output t_parse_st o_st
);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_EXP_SKIP,
        PH_EXP_SIGN,
        PH_EXP_DIG
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_neg, n_neg;
    logic [63:0] r_accum, n_accum;
    logic [63:0] r_rounded, n_rounded;
    logic [15:0] r_pl, n_pl;
    logic [13:0] r_exp, n_exp;
    logic        r_exp_neg, n_exp_neg;
    logic [15:0] r_used, n_used;
    logic        r_ovf, n_ovf;
    t_kind       r_kind;
    logic        r_on_char;
    logic [7:0]  r_stop_char;

    logic        is_dig, is_space, is_minus, is_point, is_e;
    logic [3:0]  dig_val;
    logic [63:0] push_val;
    logic        push_ovf;
    logic [17:0] exp_next;
    logic        cnt;
    logic        fin;
    t_kind       fin_kind;
    logic        fin_on_char;

    // Classify the character
    assign is_dig   = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_space = (i_ch == CH_SPACE);
    assign is_minus = (i_ch == CH_MINUS);
    assign is_point = (i_ch == CH_POINT);
    assign is_e     = (i_ch == CH_E_LO) || (i_ch == CH_E_UP);
    assign dig_val  = is_dig ? 4'(i_ch - CH_ZERO) : 4'd0;

    // Append one digit to the magnitude, flag a pass beyond the signed range
    assign push_val = {r_accum[60:0], 3'b000} + {r_accum[62:0], 1'b0} + {60'd0, dig_val};
    assign push_ovf = (r_accum > PUSH_LIMIT[dig_val]);
    assign exp_next = ({4'd0, r_exp} << 3) + ({4'd0, r_exp} << 1) + {14'd0, dig_val};

    // Next parser state for the current beat
    always_comb begin
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_accum     = r_accum;
        n_rounded   = r_rounded;
        n_pl        = r_pl;
        n_exp       = r_exp;
        n_exp_neg   = r_exp_neg;
        n_ovf       = r_ovf;
        cnt         = 1'b0;
        fin         = 1'b0;
        fin_kind    = K_ERR;
        fin_on_char = 1'b0;
        unique case (r_phase)
            PH_SKIP, PH_SIGN: begin
                if ((r_phase == PH_SKIP) && (is_space || is_minus)) begin
                    cnt = 1'b1;
                    if (is_minus) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGN;
                    end
                    fin = i_last;
                end else if (!is_dig) begin
                    fin         = 1'b1;
                    fin_on_char = 1'b1;
                end else begin
                    n_accum  = push_val;
                    n_ovf    = r_ovf | push_ovf;
                    cnt      = 1'b1;
                    n_phase  = PH_INT;
                    fin      = i_last;
                    fin_kind = K_INT;
                end
            end
            PH_INT: begin
                if (is_dig) begin
                    n_accum  = push_val;
                    n_ovf    = r_ovf | push_ovf;
                    cnt      = 1'b1;
                    fin      = i_last;
                    fin_kind = K_INT;
                end else if (is_point) begin
                    cnt       = 1'b1;
                    n_rounded = r_accum;
                    n_pl      = {11'd0, i_frac_places};
                    n_phase   = PH_FRAC;
                    fin       = i_last;
                    fin_kind  = K_FRAC;
                end else begin
                    fin         = 1'b1;
                    fin_kind    = K_INT;
                    fin_on_char = 1'b1;
                end
            end
            PH_FRAC: begin
                if (is_dig) begin
                    n_accum = push_val;
                    n_ovf   = r_ovf | push_ovf;
                    if ($signed(r_pl) > 16'sd0) begin
                        n_rounded = push_val;
                    end else if ((r_pl == 16'd0) && (dig_val >= ROUND_DIGIT)) begin
                        // first digit past the kept places rounds half up
                        n_rounded = r_accum + 64'd1;
                        n_ovf     = r_ovf | push_ovf | (r_accum >= MAG_MAX);
                    end
                    if (r_pl != PLACES_FLOOR) begin
                        n_pl = r_pl - 16'd1;
                    end
                    cnt      = 1'b1;
                    fin      = i_last;
                    fin_kind = K_FRAC;
                end else if (is_e) begin
                    cnt      = 1'b1;
                    n_phase  = PH_EXP_SKIP;
                    fin      = i_last;
                    fin_kind = K_EXP;
                end else begin
                    fin         = 1'b1;
                    fin_kind    = K_FRAC;
                    fin_on_char = 1'b1;
                end
            end
            PH_EXP_SKIP, PH_EXP_SIGN, PH_EXP_DIG: begin
                fin_kind = K_EXP;
                if ((r_phase == PH_EXP_SKIP) && (is_space || is_minus)) begin
                    cnt = 1'b1;
                    if (is_minus) begin
                        n_exp_neg = 1'b1;
                        n_phase   = PH_EXP_SIGN;
                    end
                    fin = i_last;
                end else if (is_dig) begin
                    n_exp   = (exp_next > {4'd0, EXP_CAP}) ? EXP_CAP : exp_next[13:0];
                    cnt     = 1'b1;
                    n_phase = PH_EXP_DIG;
                    fin     = i_last;
                end else begin
                    fin         = 1'b1;
                    fin_on_char = 1'b1;
                end
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase
    end

    assign n_used = (cnt && (r_used != 16'hFFFF)) ? r_used + 16'd1 : r_used;

    // Hold parser state; restart when a result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_phase   <= PH_SKIP;
            r_neg     <= 1'b0;
            r_accum   <= 64'd0;
            r_rounded <= 64'd0;
            r_pl      <= {11'd0, i_frac_places};
            r_exp     <= 14'd0;
            r_exp_neg <= 1'b0;
            r_used    <= 16'd0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.take) begin
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_accum   <= n_accum;
            r_rounded <= n_rounded;
            r_pl      <= n_pl;
            r_exp     <= n_exp;
            r_exp_neg <= n_exp_neg;
            r_used    <= n_used;
            r_ovf     <= n_ovf;
        end
    end

    // Capture how the number ended
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= K_ERR;
            r_on_char   <= 1'b0;
            r_stop_char <= 8'd0;
        end else if (i_cmd.take && fin) begin
            r_kind      <= fin_kind;
            r_on_char   <= fin_on_char;
            r_stop_char <= fin_on_char ? i_ch : 8'd0;
        end
    end

    assign o_fin_req = fin;

    always_comb begin
        o_st.accum       = r_accum;
        o_st.rounded     = r_rounded;
        o_st.places_left = r_pl;
        o_st.exp_value   = r_exp;
        o_st.exp_neg     = r_exp_neg;
        o_st.exp_dig     = (r_phase == PH_EXP_DIG);
        o_st.negative    = r_neg;
        o_st.used        = r_used;
        o_st.ovf         = r_ovf;
        o_st.kind        = r_kind;
        o_st.on_char     = r_on_char;
        o_st.stop_char   = r_stop_char;
    end

endmodule

`default_nettype wire

// ----- rtl/core/dtfp_scale.sv -----
// Scaling unit: times ten one step a cycle, divide by ten one byte a cycle.
`default_nettype none

module dtfp_scale
    import dtfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_parse_st   i_p,
    input  logic [4:0]  i_frac_places,
    output t_scale_st   o_st,
    output logic [63:0] o_work,
    output logic        o_ovf
);

    logic [63:0] r_work;
    logic [6:0]  r_iter;
    logic [2:0]  r_byte;
    logic [3:0]  r_rem;
    logic        r_ovf;

    logic [16:0] e_mag;
    logic signed [16:0] e_val;
    logic signed [16:0] total;
    logic [16:0] neg_total;
    logic [63:0] s_work;
    logic [6:0]  s_iter;
    logic        s_up;
    logic [63:0] work_x10;
    logic [7:0]  div_q;
    logic [3:0]  div_rem;

    // Total power of ten: kept places plus exponent (exponent 1 without digits)
    assign e_mag     = {3'd0, i_p.exp_value};
    assign e_val     = i_p.exp_dig ? (i_p.exp_neg ? -$signed(e_mag) : $signed(e_mag))
                                   : 17'sd1;
    assign total     = $signed({i_p.places_left[15], i_p.places_left}) + e_val;
    assign neg_total = 17'(-total);

    // Starting magnitude and step count
    always_comb begin
        s_work = i_p.accum;
        s_iter = 7'd0;
        s_up   = 1'b1;
        case (i_p.kind)
            K_INT: begin
                s_iter = {2'd0, i_frac_places};
            end
            K_FRAC: begin
                s_work = i_p.rounded;
                s_iter = ($signed(i_p.places_left) > 16'sd0) ? i_p.places_left[6:0] : 7'd0;
            end
            K_EXP: begin
                if (!total[16]) begin
                    s_iter = (total[15:0] > {9'd0, UP_STEPS_MAX}) ? UP_STEPS_MAX
                                                                  : total[6:0];
                end else begin
                    s_up   = 1'b0;
                    s_iter = (neg_total > {10'd0, DIV_STEPS_MAX}) ? DIV_STEPS_MAX
                                                                  : neg_total[6:0];
                end
            end
            default: begin
                s_work = 64'd0;
            end
        endcase
    end

    assign work_x10 = {r_work[60:0], 3'b000} + {r_work[62:0], 1'b0};

    // Restoring divide by ten over the top byte of the shifting dividend
    always_comb begin
        logic [3:0] rem;
        logic [4:0] t;
        rem = (r_byte == 3'd0) ? 4'd0 : r_rem;
        t   = 5'd0;
        for (int i = 7; i >= 0; i--) begin
            t = {rem, r_work[56 + i]};
            if (t >= 5'd10) begin
                div_q[i] = 1'b1;
                rem      = 4'(t - 5'd10);
            end else begin
                div_q[i] = 1'b0;
                rem      = t[3:0];
            end
        end
        div_rem = rem;
    end

    // Step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= 7'd0;
            r_byte <= 3'd0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.setup) begin
            r_iter <= s_iter;
            r_byte <= 3'd0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.up_step) begin
            r_iter <= r_iter - 7'd1;
            r_ovf  <= r_ovf | (r_work > SCALE_LIMIT);
        end else if (i_cmd.div_step) begin
            r_byte <= r_byte + 3'd1;
            if (r_byte == 3'd7) begin
                r_iter <= r_iter - 7'd1;
            end
        end
    end

    // Working magnitude and remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_work <= s_work;
            r_rem  <= 4'd0;
        end else if (i_cmd.up_step) begin
            r_work <= work_x10;
        end else if (i_cmd.div_step) begin
            r_work <= {r_work[55:0], div_q};
            r_rem  <= div_rem;
        end else if (i_cmd.round_up) begin
            r_work <= r_work + {63'd0, (r_rem >= ROUND_DIGIT)};
        end
    end

    always_comb begin
        o_st.setup_up   = s_up;
        o_st.iter_zero  = (r_iter == 7'd0);
        o_st.iter_one   = (r_iter == 7'd1);
        o_st.work_zero  = (r_work == 64'd0);
        o_st.byte_first = (r_byte == 3'd0);
        o_st.byte_last  = (r_byte == 3'd7);
    end

    assign o_work = r_work;
    assign o_ovf  = r_ovf;

endmodule

`default_nettype wire

// ----- rtl/core/dtfp_ctrl.sv -----
// Controller: takes characters, then sequences scaling and result hand-off.
`default_nettype none

module dtfp_ctrl
    import dtfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_free,
    input  t_status i_st,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_PARSE,
        S_SETUP,
        S_UP,
        S_DIV,
        S_ROUND,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    // Decode commands and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_PARSE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_st.fin_req) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_st.is_err) begin
                    n_state = S_EMIT;
                end else if (i_st.sc.setup_up) begin
                    n_state = S_UP;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_UP: begin
                if (i_st.sc.iter_zero || i_st.sc.work_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.up_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_st.sc.byte_first && i_st.sc.work_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_st.sc.byte_last && i_st.sc.iter_one) begin
                        n_state = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.round_up = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_PARSE;
                end
            end
            default: begin
                n_state = S_PARSE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PARSE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_PARSE);

endmodule

`default_nettype wire

// ----- rtl/core/decimal_text_to_fixed_point_top.sv -----
// Top level: configuration registers, parser, scaling unit, controller, output register.
// Throughput: one character a cycle while a number is being read; the beat that ends a
// number holds the input off until its result sits in the output register.
// After that beat the controller sets up, then emits without scaling on error, scales up by ten
// n times (n up to 64, fewer once the value is zero), or divides by ten d times (d up to 25,
// byte-wide divider) and rounds the last division, and waits while a stalled result beat holds the output.
// Reset (synchronous, active low) clears the parser, the output beat and both registers.
`default_nettype none

module decimal_text_to_fixed_point_top
    import dtfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] ch
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [63:0] value, [71:64] stop_char,
                                              // [87:72] chars_used
    output logic [OUT_TUSER_W-1:0] m_tuser,   // [0] is_error, [1] overflow,
                                              // [2] ended_on_char
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [63:0]            i_cfg_wdata
);

    logic [4:0]  r_frac_places;
    logic [63:0] r_error_value;
    logic                   r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;
    logic [OUT_TUSER_W-1:0] r_m_tuser;

    t_cmd        w_cmd;
    t_status     w_status;
    t_parse_st   w_pst;
    t_scale_st   w_sc;
    logic        w_fin_req;
    logic [63:0] w_work;
    logic        w_scale_ovf;
    logic        w_out_free;
    logic        w_err;
    logic [63:0] w_value;

    // Configuration writes; clamp the place count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_places <= 5'd0;
            r_error_value <= 64'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAC_PLACES: begin
                    r_frac_places <= (i_cfg_wdata[4:0] > MAX_FRAC_PLACES) ? MAX_FRAC_PLACES
                                                                          : i_cfg_wdata[4:0];
                end
                CFG_ERROR_VALUE: begin
                    r_error_value <= i_cfg_wdata;
                end
                default: begin
                    r_error_value <= r_error_value;
                end
            endcase
        end
    end

    dtfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_out_free (w_out_free),
        .i_st       (w_status),
        .o_in_ready (s_tready),
        .o_cmd      (w_cmd)
    );

    dtfp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_ch          (s_tdata),
        .i_last        (s_tlast),
        .i_frac_places (r_frac_places),
        .o_fin_req     (w_fin_req),
        .o_st          (w_pst)
    );

    dtfp_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_p           (w_pst),
        .i_frac_places (r_frac_places),
        .o_st          (w_sc),
        .o_work        (w_work),
        .o_ovf         (w_scale_ovf)
    );

    always_comb begin
        w_status.fin_req = w_fin_req;
        w_status.is_err  = (w_pst.kind == K_ERR);
        w_status.sc      = w_sc;
    end

    // Result value: signed magnitude, or the error value
    assign w_err      = (w_pst.kind == K_ERR);
    assign w_value    = w_err ? r_error_value
                              : (w_pst.negative ? 64'd0 - w_work : w_work);
    assign w_out_free = !r_m_tvalid || m_tready;

    // Output beat: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_m_tdata <= {w_pst.used, w_pst.stop_char, w_value};
            r_m_tuser <= {w_pst.on_char, !w_err && (w_pst.ovf || w_scale_ovf), w_err};
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

endmodule

`default_nettype wire

// ----- rtl/core/dtfp_checker.sv -----
// Port checker for the parser top level, attached by bind.
`default_nettype none

module dtfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // Reset leaves no result beat pending
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result beat survives reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // An error result never reports overflow
    a_err_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("overflow flagged on an error result");

    // A number closed by end of input carries no stop character
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[2] |-> (m_tdata[71:64] == 8'd0))
        else $error("stop character set without a stopping character");

endmodule

bind decimal_text_to_fixed_point_top dtfp_checker u_dtfp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- bench/decimal_text_to_fixed_point_top_test.sv -----
// Self-checking bench for the decimal text to fixed-point parser: directed, random and long-text runs.
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_top_test;
    import dtfp_pkg::*;

    localparam logic [63:0] POS_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT   = 64'h8000_0000_0000_0000;
    localparam int          FRAC_LIMIT  = 18;
    localparam int          EXP_SAT     = 16383;
    localparam int          PLACES_MIN  = -32768;
    localparam int          IDLE_PCT    = 29;
    localparam int          SETTLE_CYC  = 250;
    localparam int          REPORT_MAX  = 100;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_EXP_SKIP,
        PH_EXP_SIGN,
        PH_EXP_DIG
    } t_phase;

    typedef struct packed {
        logic [63:0] value;
        logic        is_error;
        logic        overflow;
        logic        ended_on_char;
        logic [7:0]  stop_char;
        logic [15:0] chars_used;
    } t_number;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata     = '0;   // [7:0] ch
    logic                   s_tlast     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // [63:0] value, [71:64] stop_char,
                                                // [87:72] chars_used
    logic [OUT_TUSER_W-1:0] m_tuser;            // [0] is_error, [1] overflow,
                                                // [2] ended_on_char
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [63:0]            i_cfg_wdata = '0;

    // Parser model state and configuration copy
    int          frac_cfg   = 0;
    logic [63:0] err_cfg    = '0;
    t_phase      ph         = PH_SKIP;
    logic        is_neg     = 1'b0;
    logic [63:0] mag_acc    = '0;
    logic [63:0] mag_rnd    = '0;
    int          places     = 0;
    int          exp_mag    = 0;
    logic        exp_is_neg = 1'b0;
    int          used_chars = 0;
    logic        ovf_seen   = 1'b0;

    t_number expected_numbers[$];
    int      fail_count = 0;
    int      chars_sent = 0;
    bit      no_stall   = 1'b0;

    decimal_text_to_fixed_point_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #15_000_000;
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void parse_restart();
        ph         = PH_SKIP;
        is_neg     = 1'b0;
        mag_acc    = '0;
        mag_rnd    = '0;
        places     = frac_cfg;
        exp_mag    = 0;
        exp_is_neg = 1'b0;
        used_chars = 0;
        ovf_seen   = 1'b0;
    endfunction

    function automatic void bump_used();
        if (used_chars < 65535)
            used_chars++;
    endfunction

    function automatic logic [63:0] shift_in_digit(logic [63:0] a, int unsigned d);
        if (a > (POS_LIMIT - d) / 10)
            ovf_seen = 1'b1;
        return a * 10 + d;
    endfunction

    function automatic logic [63:0] scale_by_ten(logic [63:0] m, int k);
        for (int i = 0; i < k && i < 64 && m != 0; i++) begin
            if (m > POS_LIMIT / 10)
                ovf_seen = 1'b1;
            m = m * 10;
        end
        return m;
    endfunction

    // Queue one finished number, then start afresh
    function automatic void post_number(logic [63:0] mag, logic err, logic on_char,
                                        logic [7:0] c);
        t_number r;
        r.value         = err ? err_cfg : (is_neg ? 64'd0 - mag : mag);
        r.is_error      = err;
        r.overflow      = !err && ovf_seen;
        r.ended_on_char = on_char;
        r.stop_char     = on_char ? c : 8'd0;
        r.chars_used    = used_chars[15:0];
        expected_numbers.push_back(r);
        parse_restart();
    endfunction

    function automatic void finish_int(logic on_char, logic [7:0] c);
        post_number(scale_by_ten(mag_acc, frac_cfg), 1'b0, on_char, c);
    endfunction

    function automatic void finish_frac(logic on_char, logic [7:0] c);
        post_number(scale_by_ten(mag_rnd, places), 1'b0, on_char, c);
    endfunction

    // Full-precision value scaled by the exponent, last division rounded half up
    function automatic void finish_exp(logic on_char, logic [7:0] c);
        int          e;
        int          total;
        logic [63:0] m;
        e = 1;
        m = mag_acc;
        if (ph == PH_EXP_DIG)
            e = exp_is_neg ? -exp_mag : exp_mag;
        total = places + e;
        if (total >= 0) begin
            m = scale_by_ten(m, total);
        end else begin
            for (int i = -1; i > total && i > -25 && m != 0; i--)
                m = m / 10;
            m = m / 10 + (((m % 10) >= 5) ? 1 : 0);
        end
        post_number(m, 1'b0, on_char, c);
    endfunction

    function automatic void parse_char(logic [7:0] c, logic is_last);
        logic        dig;
        int unsigned d;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d   = dig ? int'(c - CH_ZERO) : 0;
        case (ph)
            PH_SKIP, PH_SIGN: begin
                if (ph == PH_SKIP && (c == CH_SPACE || c == CH_MINUS)) begin
                    bump_used();
                    if (c == CH_MINUS) begin
                        is_neg = 1'b1;
                        ph     = PH_SIGN;
                    end
                    if (is_last)
                        post_number('0, 1'b1, 1'b0, 8'd0);
                end else if (!dig) begin
                    post_number('0, 1'b1, 1'b1, c);
                end else begin
                    mag_acc = shift_in_digit(mag_acc, d);
                    bump_used();
                    ph = PH_INT;
                    if (is_last)
                        finish_int(1'b0, 8'd0);
                end
            end
            PH_INT: begin
                if (dig) begin
                    mag_acc = shift_in_digit(mag_acc, d);
                    bump_used();
                    if (is_last)
                        finish_int(1'b0, 8'd0);
                end else if (c == CH_POINT) begin
                    bump_used();
                    mag_rnd = mag_acc;
                    places  = frac_cfg;
                    ph      = PH_FRAC;
                    if (is_last)
                        finish_frac(1'b0, 8'd0);
                end else begin
                    finish_int(1'b1, c);
                end
            end
            PH_FRAC: begin
                if (dig) begin
                    if (places > 0) begin
                        mag_acc = shift_in_digit(mag_acc, d);
                        mag_rnd = mag_acc;
                    end else begin
                        // first digit past the kept places rounds, the rest only feed an exponent
                        if (places == 0 && d >= 5) begin
                            if (mag_acc >= POS_LIMIT)
                                ovf_seen = 1'b1;
                            mag_rnd = mag_acc + 1;
                        end
                        mag_acc = shift_in_digit(mag_acc, d);
                    end
                    if (places > PLACES_MIN)
                        places--;
                    bump_used();
                    if (is_last)
                        finish_frac(1'b0, 8'd0);
                end else if (c == CH_E_LO || c == CH_E_UP) begin
                    bump_used();
                    ph = PH_EXP_SKIP;
                    if (is_last)
                        finish_exp(1'b0, 8'd0);
                end else begin
                    finish_frac(1'b1, c);
                end
            end
            default: begin
                if (ph == PH_EXP_SKIP && (c == CH_SPACE || c == CH_MINUS)) begin
                    bump_used();
                    if (c == CH_MINUS) begin
                        exp_is_neg = 1'b1;
                        ph         = PH_EXP_SIGN;
                    end
                    if (is_last)
                        finish_exp(1'b0, 8'd0);
                end else if (dig) begin
                    exp_mag = exp_mag * 10 + d;
                    if (exp_mag > EXP_SAT)
                        exp_mag = EXP_SAT;
                    bump_used();
                    ph = PH_EXP_DIG;
                    if (is_last)
                        finish_exp(1'b0, 8'd0);
                end else begin
                    finish_exp(1'b1, c);
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endfunction

    // Check result beats, track register writes, predict accepted beats
    always @(posedge i_clk) begin
        t_number want;
        if (!i_rst_n) begin
            frac_cfg = 0;
            err_cfg  = '0;
            parse_restart();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_numbers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t ns: result beat with nothing expected, tdata %h tuser %h",
                                 $time, m_tdata, m_tuser);
                end else begin
                    want = expected_numbers.pop_front();
                    compare_field("value", want.value, m_tdata[63:0]);
                    compare_field("stop_char", want.stop_char, m_tdata[71:64]);
                    compare_field("chars_used", want.chars_used, m_tdata[87:72]);
                    compare_field("is_error", want.is_error, m_tuser[0]);
                    compare_field("overflow", want.overflow, m_tuser[1]);
                    compare_field("ended_on_char", want.ended_on_char, m_tuser[2]);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FRAC_PLACES)
                    frac_cfg = (i_cfg_wdata[4:0] > FRAC_LIMIT) ? FRAC_LIMIT
                                                               : int'(i_cfg_wdata[4:0]);
                else if (i_cfg_idx == CFG_ERROR_VALUE)
                    err_cfg = i_cfg_wdata;
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata, s_tlast);
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk)
        m_tready <= no_stall || ($urandom_range(99) >= IDLE_PCT);

    // ---------------------------------------------------------------- stimulus

    // Offer one beat and hold it until taken; valid stays high for a following beat
    task automatic send_char(input logic [7:0] c, input logic is_last);
        while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit with_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], with_last && (i == s.len() - 1));
    endtask

    // Stop sending until every outstanding number has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_numbers.size() != 0)
            @(posedge i_clk);
    endtask

    // Registers are only touched while the parser is idle
    task automatic set_config(input logic [4:0] frac, input logic [63:0] err);
        logic [63:0] w;
        hold_until_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        w      = {$urandom, $urandom};
        w[4:0] = frac;
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_FRAC_PLACES;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_ERROR_VALUE;
        i_cfg_wdata <= err;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // One number with random content (at times malformed), ended by a stop character, the last flag or both
    task automatic send_number();
        logic [7:0] txt[$];
        int         n_int;
        int         n_frac;
        int         n_exp;
        bit         by_last;
        logic [7:0] stop;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) txt.push_back(CH_SPACE);
        if ($urandom_range(9) < 4)
            txt.push_back(CH_MINUS);
        n_int = ($urandom_range(19) == 0) ? 0 :
                ($urandom_range(9) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 4);
        repeat (n_int) txt.push_back(rand_digit());
        if ($urandom_range(9) < 6) begin
            txt.push_back(CH_POINT);
            n_frac = ($urandom_range(9) == 0) ? $urandom_range(15, 25) : $urandom_range(0, 5);
            repeat (n_frac) txt.push_back(rand_digit());
            if ($urandom_range(9) < 4) begin
                txt.push_back($urandom_range(1) ? CH_E_LO : CH_E_UP);
                if ($urandom_range(3) == 0)
                    txt.push_back(CH_SPACE);
                if ($urandom_range(1))
                    txt.push_back(CH_MINUS);
                n_exp = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 2);
                repeat (n_exp) txt.push_back(rand_digit());
            end
        end
        by_last = ($urandom_range(1) == 0);
        if (!by_last || txt.size() == 0) begin
            case ($urandom_range(5))
                0:       stop = 8'h2C;
                1:       stop = 8'h3B;
                2:       stop = CH_SPACE;
                3:       stop = CH_POINT;
                default: stop = 8'($urandom_range(255));
            endcase
            txt.push_back(stop);
            by_last = by_last || ($urandom_range(3) == 0);
        end
        for (int i = 0; i < txt.size(); i++)
            send_char(txt[i], by_last && (i == txt.size() - 1));
    endtask

    // ---------------------------------------------------------------- tests

    // Reset values of both registers: no fraction places, zero on error
    task automatic test_reset_values();
        send_char(8'h00, 1'b0);       // error stopped by the lowest byte
        send_text("-", 1'b1);         // lone minus then end of input
        send_text("3.5e", 1'b1);      // exponent mark with no digits counts as +1
    endtask

    task automatic test_directed();
        set_config(5'd2, NEG_LIMIT);
        send_char(8'hFF, 1'b1);       // error on the highest byte, also the last one
        send_text(" 12.345,", 1'b0);  // extra fraction digit rounds half up
        send_text("-2.5e-3;", 1'b0);  // negative exponent, rounded last division
        send_text("9", 1'b1);
    endtask

    task automatic test_random_numbers(input logic [4:0] frac, input logic [63:0] err);
        int target;
        set_config(frac, err);
        target = chars_sent + 130;
        while (chars_sent < target) begin
            if ($urandom_range(11) == 0)
                repeat ($urandom_range(1, 3))
                    send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
            else
                send_number();
            if ($urandom_range(49) == 0)
                hold_until_drained();
        end
        // close any number left open
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    // One long number with no idling: wrapped accumulator, saturated exponent
    task automatic test_long_text();
        set_config(5'd6, {$urandom, $urandom});
        no_stall = 1'b1;
        send_text(" -1.", 1'b0);
        repeat (100) send_char(rand_digit(), 1'b0);
        send_text("e 123456", 1'b1);
        hold_until_drained();
        no_stall = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed();
        test_random_numbers(5'd0, POS_LIMIT);
        test_random_numbers(5'd18, '1);
        test_random_numbers(5'd31, 64'd0);
        test_random_numbers(5'd19, {$urandom, $urandom});
        repeat (2) test_random_numbers(5'($urandom_range(31)), {$urandom, $urandom});
        test_long_text();

        hold_until_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
